// ===== sv/pncq_pkg.sv =====
// Shared types, constants and VGA palette ROM for the palette quantizer.
package pncq_pkg;

  localparam int unsigned VgaEntries = 256;
  localparam logic [7:0] RemapFrom = 8'd248;
  localparam logic [7:0] RemapTo = 8'd255;
  localparam logic [17:0] DistStart = 18'd262143;

  localparam logic KindLoad = 1'b0;
  localparam logic KindPixel = 1'b1;

  typedef struct packed {
    logic start;   // latch fetched color, clear best
    logic step;    // evaluate one ROM entry
    logic emit;    // latch result into output register
  } dp_cmd_t;

  typedef struct packed {
    logic last;    // the last ROM entry is being evaluated
  } dp_stat_t;

  localparam logic [23:0] VgaRom [256] = '{
    24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA, 24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
    24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF, 24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF,
    24'h000000, 24'h141414, 24'h202020, 24'h2C2C2C, 24'h383838, 24'h454545, 24'h515151, 24'h616161,
    24'h717171, 24'h828282, 24'h929292, 24'hA2A2A2, 24'hB6B6B6, 24'hCBCBCB, 24'hE3E3E3, 24'hFFFFFF,
    24'h0000FF, 24'h4100FF, 24'h7D00FF, 24'hBE00FF, 24'hFF00FF, 24'hFF00BE, 24'hFF007D, 24'hFF0041,
    24'hFF0000, 24'hFF4100, 24'hFF7D00, 24'hFFBE00, 24'hFFFF00, 24'hBEFF00, 24'h7DFF00, 24'h41FF00,
    24'h00FF00, 24'h00FF41, 24'h00FF7D, 24'h00FFBE, 24'h00FFFF, 24'h00BEFF, 24'h007DFF, 24'h0041FF,
    24'h7D7DFF, 24'h9E7DFF, 24'hBE7DFF, 24'hDF7DFF, 24'hFF7DFF, 24'hFF7DDF, 24'hFF7DBE, 24'hFF7D9E,
    24'hFF7D7D, 24'hFF9E7D, 24'hFFBE7D, 24'hFFDF7D, 24'hFFFF7D, 24'hDFFF7D, 24'hBEFF7D, 24'h9EFF7D,
    24'h7DFF7D, 24'h7DFF9E, 24'h7DFFBE, 24'h7DFFDF, 24'h7DFFFF, 24'h7DDFFF, 24'h7DBEFF, 24'h7D9EFF,
    24'hB6B6FF, 24'hC7B6FF, 24'hDBB6FF, 24'hEBB6FF, 24'hFFB6FF, 24'hFFB6EB, 24'hFFB6DB, 24'hFFB6C7,
    24'hFFB6B6, 24'hFFC7B6, 24'hFFDBB6, 24'hFFEBB6, 24'hFFFFB6, 24'hEBFFB6, 24'hDBFFB6, 24'hC7FFB6,
    24'hB6FFB6, 24'hB6FFC7, 24'hB6FFDB, 24'hB6FFEB, 24'hB6FFFF, 24'hB6EBFF, 24'hB6DBFF, 24'hB6C7FF,
    24'h000071, 24'h1C0071, 24'h380071, 24'h550071, 24'h710071, 24'h710055, 24'h710038, 24'h71001C,
    24'h710000, 24'h711C00, 24'h713800, 24'h715500, 24'h717100, 24'h557100, 24'h387100, 24'h1C7100,
    24'h007100, 24'h00711C, 24'h007138, 24'h007155, 24'h007171, 24'h005571, 24'h003871, 24'h001C71,
    24'h383871, 24'h453871, 24'h553871, 24'h613871, 24'h713871, 24'h713861, 24'h713855, 24'h713845,
    24'h713838, 24'h714538, 24'h715538, 24'h716138, 24'h717138, 24'h617138, 24'h557138, 24'h457138,
    24'h387138, 24'h387145, 24'h387155, 24'h387161, 24'h387171, 24'h386171, 24'h385571, 24'h384571,
    24'h515171, 24'h595171, 24'h615171, 24'h695171, 24'h715171, 24'h715169, 24'h715161, 24'h715159,
    24'h715151, 24'h715951, 24'h716151, 24'h716951, 24'h717151, 24'h697151, 24'h617151, 24'h597151,
    24'h517151, 24'h517159, 24'h517161, 24'h517169, 24'h517171, 24'h516971, 24'h516171, 24'h515971,
    24'h000041, 24'h100041, 24'h200041, 24'h300041, 24'h410041, 24'h410030, 24'h410020, 24'h410010,
    24'h410000, 24'h411000, 24'h412000, 24'h413000, 24'h414100, 24'h304100, 24'h204100, 24'h104100,
    24'h004100, 24'h004110, 24'h004120, 24'h004130, 24'h004141, 24'h003041, 24'h002041, 24'h001041,
    24'h202041, 24'h282041, 24'h302041, 24'h382041, 24'h412041, 24'h412038, 24'h412030, 24'h412028,
    24'h412020, 24'h412820, 24'h413020, 24'h413820, 24'h414120, 24'h384120, 24'h304120, 24'h284120,
    24'h204120, 24'h204128, 24'h204130, 24'h204138, 24'h204141, 24'h203841, 24'h203041, 24'h202841,
    24'h2C2C41, 24'h302C41, 24'h342C41, 24'h3C2C41, 24'h412C41, 24'h412C3C, 24'h412C34, 24'h412C30,
    24'h412C2C, 24'h41302C, 24'h41342C, 24'h413C2C, 24'h41412C, 24'h3C412C, 24'h34412C, 24'h30412C,
    24'h2C412C, 24'h2C4130, 24'h2C4134, 24'h2C413C, 24'h2C4141, 24'h2C3C41, 24'h2C3441, 24'h2C3041,
    24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000
  };

endpackage

// ===== sv/pncq_ctrl.sv =====
// Controller: sequences palette fetch, ROM scan and result handoff.
module pncq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  input  logic               in_pixel,
  input  logic               out_busy,
  input  logic               out_fire,
  input  pncq_pkg::dp_stat_t stat,
  output logic               in_ready,
  output pncq_pkg::dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    IDLE  = 4'b0001,
    FETCH = 4'b0010,
    SCAN  = 4'b0100,
    DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      IDLE: begin
        in_ready = 1'b1;
        if (in_fire && in_pixel) state_next = FETCH;
      end
      FETCH: begin
        cmd.start = 1'b1;
        state_next = SCAN;
      end
      SCAN: begin
        cmd.step = 1'b1;
        if (stat.last) state_next = DONE;
      end
      DONE: begin
        // hold until the output register is free
        if (!out_busy || out_fire) begin
          cmd.emit = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= IDLE;
    else state <= state_next;
  end

endmodule

// ===== sv/pncq_datapath.sv =====
// Datapath: source palette memory, shared distance unit and best-match tracking.
module pncq_datapath #(
  parameter int unsigned SOURCE_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               load_we,
  input  logic [7:0]         entry_slot,
  input  logic [23:0]        load_rgb,
  input  logic               rd_en,
  input  logic [7:0]         pixel_code,
  input  pncq_pkg::dp_cmd_t  cmd,
  output pncq_pkg::dp_stat_t stat,
  output logic [7:0]         result
);

  localparam int unsigned AW = (SOURCE_ENTRIES > 1) ? $clog2(SOURCE_ENTRIES) : 1;

  logic [23:0] mem [SOURCE_ENTRIES];
  logic [23:0] rd_data;
  logic        rd_ok;
  logic [23:0] color;
  logic [7:0]  k;
  logic [17:0] best_dist;
  logic [7:0]  best;
  logic [17:0] sq_dist;
  logic [15:0] sq_r, sq_g, sq_b;
  logic [23:0] rom;
  logic [8:0]  dr, dg, db;

  always_ff @(posedge clk) begin
    if (load_we && ({24'd0, entry_slot} < 32'(SOURCE_ENTRIES)))
      mem[entry_slot[AW-1:0]] <= load_rgb;
    if (rd_en) begin
      rd_data <= mem[pixel_code[AW-1:0]];
      rd_ok <= {24'd0, pixel_code} < 32'(SOURCE_ENTRIES);
    end
  end

  always_comb begin
    rom = pncq_pkg::VgaRom[k];
    dr = {1'b0, color[23:16]} - {1'b0, rom[23:16]};
    dg = {1'b0, color[15:8]} - {1'b0, rom[15:8]};
    db = {1'b0, color[7:0]} - {1'b0, rom[7:0]};
    dr = dr[8] ? -dr : dr;
    dg = dg[8] ? -dg : dg;
    db = db[8] ? -db : db;
    sq_r = {8'd0, dr[7:0]} * {8'd0, dr[7:0]};
    sq_g = {8'd0, dg[7:0]} * {8'd0, dg[7:0]};
    sq_b = {8'd0, db[7:0]} * {8'd0, db[7:0]};
    sq_dist = {2'b0, sq_r} + {2'b0, sq_g} + {2'b0, sq_b};
  end

  assign stat.last = (k == 8'(pncq_pkg::VgaEntries - 1));

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      color <= rd_ok ? rd_data : 24'd0;
      k <= 8'd0;
      best_dist <= pncq_pkg::DistStart;
      best <= 8'd0;
    end else if (cmd.step) begin
      k <= k + 8'd1;
      if (sq_dist < best_dist) begin
        best_dist <= sq_dist;
        best <= k;
      end
    end
  end

  assign result = (best >= pncq_pkg::RemapFrom) ? pncq_pkg::RemapTo : best;

endmodule

// ===== sv/palette_nearest_color_quantizer_core.sv =====
// Top level of the nearest VGA palette color quantizer.
// Usage:
//   Input channel (in_valid/in_stall) carries one word per item. kind = 0
//   writes {red, green, blue} into source palette entry entry_slot and
//   gives no result (slots at or above SOURCE_ENTRIES are dropped). kind = 1
//   quantizes the color held in entry pixel_code (black if out of range).
//   Output channel (out_valid/out_stall) carries vga_code, the nearest of
//   the 256 VGA colors by squared RGB distance, lowest index on a tie,
//   indexes 248 and up reported as 255.
//   Pixel flow: the palette memory is read at the accepting edge, the color
//   is loaded, the 256 ROM entries pass the single distance unit in turn,
//   and the result is handed off to the output register.
//   The ROM scan sets the rate: a new pixel is taken only once the last one
//   has been handed off and the controller is idle again; load words
//   are taken one per cycle while idle.
//   A finished result sits in the output register; a new pixel is taken
//   while the receiver stalls, and the scan waits only if the register is
//   still full when it ends.
//   Reset clears control state; the source palette is not cleared and must
//   be written before its entries are used.
module palette_nearest_color_quantizer_core #(
  parameter int unsigned SOURCE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] entry_slot,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] pixel_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] vga_code
);

  pncq_pkg::dp_cmd_t  cmd;
  pncq_pkg::dp_stat_t stat;
  logic in_ready, in_fire, out_fire;
  logic [7:0] result;

  assign in_stall = !in_ready;
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && !out_stall;

  pncq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_pixel(kind == pncq_pkg::KindPixel),
    .out_busy(out_valid), .out_fire(out_fire), .stat(stat), .in_ready(in_ready), .cmd(cmd)
  );

  pncq_datapath #(.SOURCE_ENTRIES(SOURCE_ENTRIES)) u_dp (
    .clk(clk),
    .load_we(in_fire && kind == pncq_pkg::KindLoad),
    .entry_slot(entry_slot), .load_rgb({red, green, blue}),
    .rd_en(in_fire && kind == pncq_pkg::KindPixel),
    .pixel_code(pixel_code), .cmd(cmd), .stat(stat), .result(result)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (out_fire) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) vga_code <= result;
  end

endmodule

// ===== test/palette_nearest_color_quantizer_core_checker.sv =====
// Checker for the palette quantizer: watches both channels, predicts and compares.
module palette_nearest_color_quantizer_core_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       kind,
  input  logic [7:0] entry_slot,
  input  logic [7:0] red,
  input  logic [7:0] green,
  input  logic [7:0] blue,
  input  logic [7:0] pixel_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] vga_code,
  output int         failures,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [23:0] shadow_palette [256];
  logic [7:0]  vga_codes_due [$];

  function automatic logic [7:0] nearest_vga_code(logic [23:0] rgb);
    int best_dist;
    int sq_dist;
    int dr, dg, db;
    logic [7:0] best;
    best_dist = 999999;
    best = 8'd0;
    for (int k = 0; k < pncq_pkg::VgaEntries; k++) begin
      dr = int'(rgb[23:16]) - int'(pncq_pkg::VgaRom[k][23:16]);
      dg = int'(rgb[15:8]) - int'(pncq_pkg::VgaRom[k][15:8]);
      db = int'(rgb[7:0]) - int'(pncq_pkg::VgaRom[k][7:0]);
      sq_dist = dr * dr + dg * dg + db * db;
      // strict compare keeps the lower index on a tie
      if (sq_dist < best_dist) begin
        best_dist = sq_dist;
        best = 8'(k);
      end
    end
    return (best >= pncq_pkg::RemapFrom) ? pncq_pkg::RemapTo : best;
  endfunction

  initial failures = 0;
  assign pending = vga_codes_due.size();

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        if (kind == pncq_pkg::KindLoad) begin
          shadow_palette[entry_slot] = {red, green, blue};
        end else begin
          vga_codes_due.push_back(nearest_vga_code(shadow_palette[pixel_code]));
        end
      end
      if (out_valid && !out_stall) begin
        if (vga_codes_due.size() == 0) begin
          $display("%t: unexpected word vga_code=%0d", $time, vga_code);
          failures++;
        end else if (vga_codes_due[0] !== vga_code) begin
          $display("%t: vga_code expected %0d actual %0d", $time, vga_codes_due[0], vga_code);
          failures++;
          void'(vga_codes_due.pop_front());
        end else begin
          void'(vga_codes_due.pop_front());
        end
      end
    end
  end
endmodule

// ===== test/palette_nearest_color_quantizer_core_test.sv =====
// Testbench top for the palette quantizer: stimulus, receiver stalls and verdict.
module palette_nearest_color_quantizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = pncq_pkg::KindLoad;
  logic [7:0] entry_slot = '0;
  logic [7:0] red = '0;
  logic [7:0] green = '0;
  logic [7:0] blue = '0;
  logic [7:0] pixel_code = '0;
  logic       out_valid;
  logic       out_stall = 1'b1;
  logic [7:0] vga_code;
  int         failures;
  int         pending;

  bit         slot_loaded [256];
  bit         idle_on = 1'b0;
  bit         hold_off_req = 1'b0;

  always #5 clk = ~clk;

  palette_nearest_color_quantizer_core i_dut (.*);

  palette_nearest_color_quantizer_core_checker i_checker (.*);

  task automatic send_word(logic k, logic [7:0] slot, logic [23:0] rgb, logic [7:0] code);
    int gap;
    gap = idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    entry_slot <= slot;
    {red, green, blue} <= rgb;
    pixel_code <= code;
    do @(posedge clk); while (in_stall);
    if (k == pncq_pkg::KindLoad) slot_loaded[slot] = 1'b1;
  endtask

  task automatic load_color(logic [7:0] slot, logic [23:0] rgb);
    send_word(pncq_pkg::KindLoad, slot, rgb, 8'($urandom));
  endtask

  task automatic quantize(logic [7:0] code);
    send_word(pncq_pkg::KindPixel, 8'($urandom), 24'($urandom), code);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // receiver: random stall per word while idle_on is set, one long hold-off on request
  initial begin
    int n;
    bit held_off;
    held_off = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off_req && !held_off) begin
        out_stall <= 1'b1;
        repeat (3000) @(posedge clk);
        held_off = 1'b1;
      end
      n = idle_on ? $urandom_range(0, 12) : 0;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [7:0] code;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: corners, ties, exact ROM hits, reload of a slot
    load_color(8'd0, 24'h000000);
    load_color(8'd255, 24'hFFFFFF);
    load_color(8'd1, 24'h555555);
    load_color(8'd2, 24'hFF0000);
    load_color(8'd3, 24'h2C4141);
    load_color(8'd4, 24'h010101);
    load_color(8'd128, 24'h808080);
    quantize(8'd0);
    quantize(8'd255);
    quantize(8'd1);
    quantize(8'd2);
    quantize(8'd3);
    quantize(8'd4);
    quantize(8'd128);
    load_color(8'd128, 24'h00FF00);
    quantize(8'd128);
    load_color(8'd5, 24'h7F7F7F);
    quantize(8'd5);
    quantize(8'd5);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      idle_on = phase[0];
      if (phase == 2) hold_off_req = 1'b1;
      for (int i = 0; i < 390; i++) begin
        if ($urandom_range(0, 9) < 4) begin
          load_color(8'($urandom), 24'($urandom));
        end else begin
          // only quantize entries that were loaded
          code = 8'($urandom);
          while (!slot_loaded[code]) code = 8'($urandom);
          quantize(code);
        end
      end
      // hold the sender until every result is in
      if (phase == 3) drain();
    end
    drain();

    if (failures == 0) begin
      $display("palette_nearest_color_quantizer_core_test passed");
    end else begin
      $display("palette_nearest_color_quantizer_core_test failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("palette_nearest_color_quantizer_core_test failed");
    $finish;
  end
endmodule
